// ----- rtl/bst_pkg.sv -----
package bst_pkg;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;

   localparam logic [2:0] KIND_KEYWORD = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd2;
   localparam logic [2:0] KIND_SYMBOL  = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;

   localparam int KW_COUNT = 6;

   typedef logic [KW_COUNT-1:0] kw_mask_type;

   // keywords: int, float, if, else, while, return
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6};
   localparam logic [7:0] KW_TEXT [KW_COUNT][6] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"r", "e", "t", "u", "r", "n"}
   };

   function automatic logic is_alpha_us(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) || c == 8'd95;
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
             (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

   // narrows the keyword candidates by the character stored at position pos
   function automatic kw_mask_type kw_step(input kw_mask_type cand, input logic [2:0] pos,
                                           input logic [7:0] c);
      kw_mask_type res;
      res = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos < KW_LEN[k] && pos < 3'd6)
            res[k] = cand[k] && (c == KW_TEXT[k][pos]);
      end
      return res;
   endfunction

endpackage

// ----- rtl/byte_stream_tokenizer_top.sv -----
// byte stream tokenizer
// req channel: one text byte per transaction (req_char_code); byte 0 ends the line
// and flushes a pending word or number. rsp channel: one token character per
// transaction with its kind, an end marker on the last character and a cut flag
// when characters beyond MAX_TOKEN_LEN were dropped.
// a letter, digit or underscore that extends the current word or number is
// stored in the word memory and gives no transaction.
// the byte that ends a word or number starts a flush: the stored characters are
// read from the word memory, one read port, one character per cycle when the
// receiver keeps up; then that byte is handled (a new word, a symbol or nothing).
// the first flushed character passes the memory read register, then the output register.
// a symbol or unknown byte is loaded into the output register in the accept cycle
// when it is free, else once it frees up; an ending byte that is a symbol waits in
// ST_EMIT after the last flushed character until the output register frees up.
// the input is not taken while a flush or a symbol is pending; a stall on rsp
// holds the output register and the flush in place, nothing is lost.
// keyword matching runs as the characters are stored, so the kind is known when the flush starts.
// reset: synchronous, clears the scan state and the output valid; the word memory
// needs no clearing, only entries written for the current token are read.
module byte_stream_tokenizer_top
   import bst_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_token_char,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_token_end,
   output logic       rsp_token_cut
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam int IDX_W = $clog2(MAX_TOKEN_LEN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic        ovf_ff, ovf_in;
   kw_mask_type cand_ff, cand_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_end_ff, rsp_end_in;
   logic        rsp_cut_ff, rsp_cut_in;

   logic [7:0]  word_mem [MAX_TOKEN_LEN];
   logic [7:0]  rd_data_ff;
   logic        wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [7:0]  wr_data;

   logic        req_fire, slot_free, cont, flush_last, kw_hit, len_small, start_go;
   logic [7:0]  start_byte;
   kw_mask_type len_match;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cont = (mode_ff == MODE_WORD &&
                  (is_alpha_us(req_char_code) || is_num_char(req_char_code))) ||
                 (mode_ff == MODE_NUM && is_num_char(req_char_code));

   assign flush_last = (LEN_W'(idx_ff) + LEN_W'(1)) == len_ff;
   assign len_small  = (len_ff >> 3) == '0;
   assign start_byte = (state_ff == ST_FLUSH) ? byte_ff : req_char_code;

   always_comb begin
      for (int k = 0; k < KW_COUNT; k++)
         len_match[k] = (len_ff == LEN_W'(KW_LEN[k]));
   end
   assign kw_hit = !ovf_ff && |(cand_ff & len_match);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      cand_in      = cand_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_cut_in   = rsp_cut_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = req_char_code;
      rd_en        = 1'b0;
      rd_addr      = '0;
      start_go     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (cont) begin
                  if (len_ff < LEN_W'(MAX_TOKEN_LEN)) begin
                     wr_en   = 1'b1;
                     wr_addr = len_ff[IDX_W-1:0];
                     len_in  = len_ff + LEN_W'(1);
                     cand_in = kw_step(cand_ff, len_ff[2:0], req_char_code) &
                               {KW_COUNT{len_small}};
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (mode_ff != MODE_IDLE) begin
                  // token ends: read it back from the first entry
                  kind_in  = (mode_ff == MODE_WORD) ? (kw_hit ? KIND_KEYWORD : KIND_IDENT)
                                                    : KIND_NUMBER;
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  byte_in  = req_char_code;
                  state_in = ST_FLUSH;
               end else begin
                  start_go = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_data_ff;
               rsp_kind_in  = kind_ff;
               rsp_end_in   = flush_last;
               rsp_cut_in   = ovf_ff;
               if (!flush_last) begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + IDX_W'(1);
               end else begin
                  state_in = ST_IDLE;
                  start_go = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = byte_ff;
               rsp_kind_in  = is_punct(byte_ff) ? KIND_SYMBOL : KIND_UNKNOWN;
               rsp_end_in   = 1'b1;
               rsp_cut_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // handle a byte with no token pending
      if (start_go) begin
         mode_in = MODE_IDLE;
         len_in  = '0;
         ovf_in  = 1'b0;
         if (is_alpha_us(start_byte) || is_num_char(start_byte)) begin
            mode_in = is_num_char(start_byte) ? MODE_NUM : MODE_WORD;
            len_in  = LEN_W'(1);
            cand_in = kw_step({KW_COUNT{1'b1}}, 3'd0, start_byte);
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = start_byte;
         end else if (start_byte != 8'd0 && !is_blank(start_byte)) begin
            if (state_ff == ST_IDLE && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = start_byte;
               rsp_kind_in  = is_punct(start_byte) ? KIND_SYMBOL : KIND_UNKNOWN;
               rsp_end_in   = 1'b1;
               rsp_cut_in   = 1'b0;
            end else begin
               byte_in  = start_byte;
               state_in = ST_EMIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff     <= cand_in;
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      rsp_char_ff <= rsp_char_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_cut_ff  <= rsp_cut_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         word_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= word_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_char = rsp_char_ff;
   assign rsp_token_kind = rsp_kind_ff;
   assign rsp_token_end  = rsp_end_ff;
   assign rsp_token_cut  = rsp_cut_ff;

   // a flush only runs on a pending, non-empty token
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> mode_ff != MODE_IDLE && len_ff != '0)
      else $error("flush without a pending token");

   // between tokens the length and cut flag are clear
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> len_ff == '0 && !ovf_ff)
      else $error("stale token length between tokens");

   // characters are dropped only once the buffer is full
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> len_ff == LEN_W'(MAX_TOKEN_LEN))
      else $error("cut flag set on a partly filled buffer");

   // the flush index never passes the token length
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> LEN_W'(idx_ff) < len_ff)
      else $error("flush index beyond token length");

   // a memory write never collides with a flush read
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("word memory read and write in the same cycle");

endmodule

// ----- sim/token_stream_checker.sv -----
`timescale 1ns / 100ps

module token_stream_checker
   import bst_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_token_char,
   input  logic [2:0] rsp_token_kind,
   input  logic       rsp_token_end,
   input  logic       rsp_token_cut,
   output int         fail_count,
   output int         pending_chars,
   output int         bytes_taken,
   output int         tokens_done,
   output int         keywords_done,
   output int         cut_tokens_done
);

   typedef struct packed {
      logic [7:0] ch;
      logic [2:0] kind;
      logic       last;
      logic       cut;
   } token_char_type;

   token_char_type expected_chars [$];
   token_char_type oldest;

   // scanner state kept alongside the block
   logic [1:0] scan_state;
   logic [7:0] word_buf [MAX_TOKEN_LEN];
   int         word_len;
   logic       word_cut;

   string keyword_list [6] = '{"int", "float", "if", "else", "while", "return"};

   initial begin
      fail_count      = 0;
      pending_chars   = 0;
      bytes_taken     = 0;
      tokens_done     = 0;
      keywords_done   = 0;
      cut_tokens_done = 0;
   end

   function automatic logic starts_word(input logic [7:0] c);
      return c inside {[8'd65:8'd90], [8'd97:8'd122], 8'd95};
   endfunction

   function automatic logic numeral(input logic [7:0] c);
      return c inside {[8'd48:8'd57]};
   endfunction

   function automatic logic white(input logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic punctuation(input logic [7:0] c);
      return c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd94], 8'd96,
                       [8'd123:8'd126]};
   endfunction

   function automatic logic word_is_keyword();
      logic hit;
      if (word_cut)
         return 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (keyword_list[k].len() == word_len) begin
            hit = 1'b1;
            for (int i = 0; i < word_len; i++)
               if (keyword_list[k][i] != word_buf[i])
                  hit = 1'b0;
            if (hit)
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic keep_char(input logic [7:0] c);
      if (word_len < MAX_TOKEN_LEN) begin
         word_buf[word_len] = c;
         word_len++;
      end else begin
         word_cut = 1'b1;
      end
   endtask

   task automatic flush_word();
      logic [2:0] kind;
      if (scan_state == MODE_WORD)
         kind = word_is_keyword() ? KIND_KEYWORD : KIND_IDENT;
      else
         kind = KIND_NUMBER;
      for (int i = 0; i < word_len; i++)
         expected_chars.push_back('{word_buf[i], kind, (i == word_len - 1), word_cut});
      scan_state = MODE_IDLE;
      word_len   = 0;
      word_cut   = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] c);
      logic absorbed;
      absorbed = 1'b0;
      if (scan_state == MODE_WORD) begin
         if (starts_word(c) || numeral(c)) begin
            keep_char(c);
            absorbed = 1'b1;
         end else begin
            flush_word();
         end
      end else if (scan_state == MODE_NUM) begin
         if (numeral(c)) begin
            keep_char(c);
            absorbed = 1'b1;
         end else begin
            flush_word();
         end
      end
      // the ending byte is then handled as if nothing were pending
      if (!absorbed && c != 8'd0 && !white(c)) begin
         if (starts_word(c)) begin
            scan_state = MODE_WORD;
            word_len   = 0;
            word_cut   = 1'b0;
            keep_char(c);
         end else if (numeral(c)) begin
            scan_state = MODE_NUM;
            word_len   = 0;
            word_cut   = 1'b0;
            keep_char(c);
         end else begin
            expected_chars.push_back('{c, punctuation(c) ? KIND_SYMBOL : KIND_UNKNOWN,
                                       1'b1, 1'b0});
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_state = MODE_IDLE;
         word_len   = 0;
         word_cut   = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected rsp transaction, char %h kind %0d end %b cut %b",
                        $time, rsp_token_char, rsp_token_kind, rsp_token_end,
                        rsp_token_cut);
               fail_count++;
            end else begin
               oldest = expected_chars.pop_front();
               check_field("token_char", oldest.ch, rsp_token_char);
               check_field("token_kind", oldest.kind, rsp_token_kind);
               check_field("token_end", oldest.last, rsp_token_end);
               check_field("token_cut", oldest.cut, rsp_token_cut);
               if (oldest.last) begin
                  tokens_done++;
                  if (oldest.kind == KIND_KEYWORD)
                     keywords_done++;
                  if (oldest.cut)
                     cut_tokens_done++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_byte(req_char_code);
            bytes_taken++;
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

// ----- sim/byte_stream_tokenizer_top_tb.sv -----
`timescale 1ns / 100ps

module byte_stream_tokenizer_top_tb;

   localparam int TOKEN_LEN    = 32;
   localparam int LIMIT_CYCLES = 600000;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_token_char;
   logic [2:0] rsp_token_kind;
   logic       rsp_token_end;
   logic       rsp_token_cut;

   int   fail_count;
   int   pending_chars;
   int   bytes_taken;
   int   tokens_done;
   int   keywords_done;
   int   cut_tokens_done;

   int   cycle_count = 0;
   int   bytes_sent  = 0;
   int   rsp_stall   = 0;
   logic steady      = 1'b0;

   string keyword_pick [6] = '{"int", "float", "if", "else", "while", "return"};

   byte_stream_tokenizer_top #(
      .MAX_TOKEN_LEN(TOKEN_LEN)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_token_char(rsp_token_char),
      .rsp_token_kind(rsp_token_kind),
      .rsp_token_end (rsp_token_end),
      .rsp_token_cut (rsp_token_cut)
   );

   token_stream_checker #(
      .MAX_TOKEN_LEN(TOKEN_LEN)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_char (rsp_token_char),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_end  (rsp_token_end),
      .rsp_token_cut  (rsp_token_cut),
      .fail_count     (fail_count),
      .pending_chars  (pending_chars),
      .bytes_taken    (bytes_taken),
      .tokens_done    (tokens_done),
      .keywords_done  (keywords_done),
      .cut_tokens_done(cut_tokens_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run stopped after %0d cycles, %0d token chars still owed",
                  $time, cycle_count, pending_chars);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver stalls
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   function automatic logic [7:0] word_char(input logic first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26)
         return 8'(65 + r);
      if (r < 52)
         return 8'(97 + (r - 26));
      if (r == 52)
         return 8'd95;
      return 8'(48 + (r - 53));
   endfunction

   task automatic send_word(input int n);
      send_byte(word_char(1'b1));
      for (int i = 1; i < n; i++)
         send_byte(word_char(1'b0));
   endtask

   task automatic send_number(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'(48 + $urandom_range(0, 9)));
   endtask

   task automatic send_random_token();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         send_text(keyword_pick[$urandom_range(0, 5)]);
      end else if (r < 45) begin
         send_word($urandom_range(1, 8));
      end else if (r < 60) begin
         send_number($urandom_range(1, 6));
      end else if (r < 72) begin
         do
            c = 8'($urandom_range(33, 126));
         while (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122], 8'd95});
         send_byte(c);
      end else if (r < 84) begin
         c = 8'($urandom_range(8, 13));
         send_byte(c == 8'd8 ? 8'd32 : c);
      end else if (r < 93) begin
         case ($urandom_range(0, 3))
            0:       c = 8'($urandom_range(1, 8));
            1:       c = 8'($urandom_range(14, 31));
            2:       c = 8'd127;
            default: c = 8'($urandom_range(128, 255));
         endcase
         send_byte(c);
      end else begin
         send_byte(8'd0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // keyword ended by a symbol, identifier ended by a symbol
      send_text("if(x1)");
      send_text("int 42;");
      send_byte(8'hFF);
      // line end flushes a pending word
      send_text("_a9");
      send_byte(8'h00);
      send_byte(8'h09);
      send_byte(8'h7F);
      send_byte(8'h01);
      // number ended by an unknown byte
      send_text("007");
      send_byte(8'h80);

      // buffer boundary: a number that fills it exactly, then an overflowing word
      send_number(TOKEN_LEN);
      send_byte(8'd32);
      send_word(TOKEN_LEN + 2);
      send_byte(8'd44);

      while (bytes_sent < 120) begin
         steady = (bytes_sent >= 100 && bytes_sent < 112);
         send_random_token();
      end
      steady = 1'b0;
      send_byte(8'd0);
      req_valid <= 1'b0;

      while (pending_chars != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d text bytes and %0d tokens (%0d keywords, %0d cut)",
               bytes_taken, tokens_done, keywords_done, cut_tokens_done);
      if (fail_count == 0 && pending_chars == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bst_pkg.sv
rtl/byte_stream_tokenizer_top.sv
sim/token_stream_checker.sv
sim/byte_stream_tokenizer_top_tb.sv
